// File: design/brm_pkg.sv
package brm_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Register index of the enable bit
    localparam logic REG_ENABLE = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] address;
        logic [15:0] length;
        logic [2:0]  type_mask;
    } brm_in_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [4:0] entry_count;
    } brm_out_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  type_mask;
        logic [23:0] start;
        logic [15:0] span;
    } brm_entry_t;

    typedef struct packed {
        logic capture;  // register compare flags against the incoming word
        logic clear;    // drop the entry
        logic shift;    // take the neighbour's entry
        logic load;     // write the held word as a new entry
    } brm_cell_ctrl_t;

endpackage

// File: design/breakpoint_range_matcher.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall brm_in_t  (kind, address, length, type_mask)
// rsp       out        rsp_valid/rsp_stall brm_out_t (hit, status, entry_count)
// apb       in         psel/penable/pready enable bit at byte address 0
//
// Each word goes through compare and commit: at acceptance every cell registers its compare
// flags against the word; in the next cycle the table commits (append, gap
// closing shift, clear) and the result is loaded into the output register.
// A new word is not taken while the table is still committing the previous one.
// Reset empties the table and clears enable; entry payloads are not reset.
// A stalled result holds in the output register; a new word is taken only
// once that register is free or being taken in the same cycle.
module breakpoint_range_matcher #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  brm_pkg::brm_in_t  req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output brm_pkg::brm_out_t rsp_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import brm_pkg::*;

    localparam int CW = $clog2(NUM_ENTRIES + 1);

    // Inclusive prefix OR, log-depth
    function automatic logic [NUM_ENTRIES-1:0] prefix_or(input logic [NUM_ENTRIES-1:0] v);
        logic [NUM_ENTRIES-1:0] acc;
        acc = v;
        for (int s = 1; s < NUM_ENTRIES; s = s * 2)
        begin
            acc = acc | (acc << s);
        end
        return acc;
    endfunction

    logic                   enable_reg;
    logic                   busy_reg;
    brm_in_t                item_reg;
    logic [CW-1:0]          held_reg, held_next;
    logic                   rsp_valid_reg;
    brm_out_t               rsp_word_reg;
    brm_out_t               result;

    logic                   accept, commit, table_full, found;
    logic [NUM_ENTRIES-1:0] del_vec, chk_vec, drop_vec, load_vec;
    brm_cell_ctrl_t         cell_ctrl [NUM_ENTRIES];
    brm_entry_t             chain     [NUM_ENTRIES+1];

    // Configuration port: always ready, one register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, enable_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    // Handshake: hold off while committing or while a result stalls
    assign req_stall = busy_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign commit    = busy_reg;

    // Row of cells; the last one sees an empty neighbour
    assign chain[NUM_ENTRIES] = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_ENTRIES; k++)
        begin : g_cell
            assign cell_ctrl[k] = '{capture: accept,
                                    clear:   commit && (item_reg.kind == KIND_CLEAR),
                                    shift:   drop_vec[k],
                                    load:    load_vec[k]};
            brm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl[k]),
                .probe      (req_word),
                .item       (item_reg),
                .next_entry (chain[k+1]),
                .entry      (chain[k]),
                .del_match  (del_vec[k]),
                .chk_match  (chk_vec[k])
            );
            assign load_vec[k] = commit && (item_reg.kind == KIND_ADD) && !table_full
                                 && (held_reg == CW'(k));
        end
    endgenerate

    // Oldest matching entry and everything above it move down one place
    assign drop_vec   = (commit && (item_reg.kind == KIND_DEL)) ? prefix_or(del_vec) : '0;
    assign found      = |del_vec;
    assign table_full = (held_reg == CW'(NUM_ENTRIES));

    always_comb
    begin
        held_next     = held_reg;
        result.hit    = 1'b0;
        result.status = ST_OK;
        unique case (item_reg.kind)
            KIND_ADD:
            begin
                if (table_full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    held_next = held_reg + CW'(1);
                end
            end
            KIND_DEL:
            begin
                if (found)
                begin
                    held_next = held_reg - CW'(1);
                end
                else
                begin
                    result.status = ST_NOTFOUND;
                end
            end
            KIND_CHECK:
            begin
                result.hit = enable_reg && (|chk_vec);
            end
            KIND_CLEAR:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
        // Count reported modulo 32
        result.entry_count = 5'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            if (commit)
            begin
                held_reg      <= held_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_word;
        end
        if (commit)
        begin
            rsp_word_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Checks
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> req_stall)
        else $error("word accepted during commit");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !rsp_valid_reg)
        else $error("commit would overwrite a pending result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(NUM_ENTRIES))
        else $error("entry count beyond table depth");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (item_reg.kind == KIND_DEL) && found |=> held_reg == $past(held_reg) - CW'(1))
        else $error("delete did not shrink the table");

endmodule

// File: design/brm_cell.sv
module brm_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  brm_pkg::brm_cell_ctrl_t ctrl,
    input  brm_pkg::brm_in_t        probe,
    input  brm_pkg::brm_in_t        item,
    input  brm_pkg::brm_entry_t     next_entry,
    output brm_pkg::brm_entry_t     entry,
    output logic                    del_match,
    output logic                    chk_match
);
    import brm_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  type_reg, type_next;
    logic [23:0] start_reg, start_next;
    logic [15:0] span_reg, span_next;
    logic        del_match_reg, chk_match_reg;
    logic        del_hit, chk_hit;
    logic        overlap;
    logic [24:0] upper_bound, access_end;

    // Compare the incoming word with this entry
    assign overlap     = (type_reg & probe.type_mask) != 3'b000;
    assign upper_bound = {1'b0, start_reg} + {9'b0, span_reg};
    assign access_end  = {1'b0, probe.address} + {9'b0, probe.length};
    assign del_hit     = valid_reg && overlap && (start_reg == probe.address);
    assign chk_hit     = valid_reg && overlap
                         && ({1'b0, probe.address} <= upper_bound)
                         && (access_end >= {1'b0, start_reg});

    always_comb
    begin
        valid_next = valid_reg;
        type_next  = type_reg;
        start_next = start_reg;
        span_next  = span_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_entry.valid;
            type_next  = next_entry.type_mask;
            start_next = next_entry.start;
            span_next  = next_entry.span;
        end
        else if (ctrl.load)
        begin
            valid_next = 1'b1;
            type_next  = item.type_mask;
            start_next = item.address;
            span_next  = item.length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            del_match_reg <= 1'b0;
            chk_match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.capture)
            begin
                del_match_reg <= del_hit;
                chk_match_reg <= chk_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        start_reg <= start_next;
        span_reg  <= span_next;
    end

    assign entry     = '{valid: valid_reg, type_mask: type_reg, start: start_reg,
                         span: span_reg};
    assign del_match = del_match_reg;
    assign chk_match = chk_match_reg;

endmodule
